// ----- design/bsc_pkg.sv -----
package bsc_pkg;

   localparam int TEMP_FRACTION_BITS_DEF     = 16;
   localparam int PRESSURE_FRACTION_BITS_DEF = 6;

   // register indexes
   localparam logic [1:0] REG_TEMP_TRIM  = 2'd0;
   localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
   localparam logic [1:0] REG_PRESS_MID  = 2'd2;
   localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;

   // decoded trim coefficients, all as signed values
   typedef struct packed {
      logic signed [16:0] t1;
      logic signed [16:0] t2;
      logic signed [7:0]  t3;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic signed [16:0] p5;
      logic signed [16:0] p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } trim_type;

endpackage

// ----- design/bsc_regs.sv -----
module bsc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bsc_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]    csr_data,
   output bsc_pkg::trim_type                 trim
);
   import bsc_pkg::*;

   logic [39:0] temp_ff, temp_in;
   logic [47:0] low_ff, low_in, mid_ff, mid_in;
   logic [31:0] high_ff, high_in;

   assign csr_ready = 1'b1;

   // register write decode, indexes beyond the list are dropped
   always_comb begin
      temp_in = temp_ff;
      low_in  = low_ff;
      mid_in  = mid_ff;
      high_in = high_ff;
      if (csr_valid && csr_index[CSR_ADDR_W-1] == 1'b0) begin
         case (csr_index[1:0])
            REG_TEMP_TRIM:  temp_in = csr_data[39:0];
            REG_PRESS_LOW:  low_in  = csr_data;
            REG_PRESS_MID:  mid_in  = csr_data;
            REG_PRESS_HIGH: high_in = csr_data[31:0];
            default:        temp_in = temp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         low_ff  <= '0;
         mid_ff  <= '0;
         high_ff <= '0;
      end else begin
         temp_ff <= temp_in;
         low_ff  <= low_in;
         mid_ff  <= mid_in;
         high_ff <= high_in;
      end
   end

   // field split
   assign trim.t1  = {1'b0, temp_ff[15:0]};
   assign trim.t2  = {1'b0, temp_ff[31:16]};
   assign trim.t3  = temp_ff[39:32];
   assign trim.p1  = low_ff[15:0];
   assign trim.p2  = low_ff[31:16];
   assign trim.p3  = low_ff[39:32];
   assign trim.p4  = low_ff[47:40];
   assign trim.p5  = {1'b0, mid_ff[15:0]};
   assign trim.p6  = {1'b0, mid_ff[31:16]};
   assign trim.p7  = mid_ff[39:32];
   assign trim.p8  = mid_ff[47:40];
   assign trim.p9  = high_ff[15:0];
   assign trim.p10 = high_ff[23:16];
   assign trim.p11 = high_ff[31:24];

endmodule

// ----- design/bsc_pipe.sv -----
module bsc_pipe #(
   parameter int TEMP_FRACTION_BITS     = bsc_pkg::TEMP_FRACTION_BITS_DEF,
   parameter int PRESSURE_FRACTION_BITS = bsc_pkg::PRESSURE_FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bsc_pkg::trim_type trim,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [23:0]       in_ut,
   input  logic [23:0]       in_up,
   output logic              out_valid,
   output logic [23:0]       out_temp,
   output logic [23:0]       out_pres,
   output logic              out_sat
);
   import bsc_pkg::*;

   localparam int NSTAGE = 7;

   logic [NSTAGE-1:0] vld_ff, vld_in;

   // stage 1: offset reading and its square
   logic signed [25:0] d_ff, d_in;
   logic signed [51:0] dd_ff, dd_in;
   logic signed [24:0] up1_ff;
   // stage 2: exact temperature times 2^48
   logic signed [71:0] tn_ff, tn_in;
   logic signed [24:0] up2_ff;
   // stage 3: clamp temperature, tq square
   logic signed [28:0] tq3_ff, tq3_in;
   logic signed [39:0] tsq3_ff, tsq3_in;
   logic [23:0]        temp3_ff, temp3_in;
   logic               tsat3_ff, tsat3_in;
   logic signed [24:0] up3_ff;
   logic signed [49:0] upup3_ff, upup3_in;
   // stage 4: cube, single products
   logic signed [49:0] tcu4_ff, tcu4_in;
   logic signed [39:0] tsq4_ff;
   logic signed [28:0] tq4_ff;
   logic signed [23:0] temp4_ff;
   logic               tsat4_ff;
   logic signed [24:0] up4_ff;
   logic signed [59:0] p11uu4_ff, p11uu4_in;
   // stage 5: polynomial sums
   logic signed [47:0] acc5_ff, acc5_in;
   logic signed [39:0] q5_ff, q5_in;
   logic signed [39:0] k5_ff, k5_in;
   logic signed [33:0] c5_ff, c5_in;
   logic [23:0]        temp5_ff;
   logic               tsat5_ff;
   logic signed [24:0] up5_ff;
   // stage 6: products with raw pressure
   logic signed [55:0] acc6_ff, acc6_in;
   logic signed [39:0] ku6_ff, ku6_in;
   logic [23:0]        temp6_ff;
   logic               tsat6_ff;
   logic signed [24:0] up6_ff;
   // stage 7: final square term, clamp
   logic [23:0] temp7_ff, pres7_ff, pres7_in;
   logic        sat7_ff, sat7_in;

   assign vld_in = {vld_ff[NSTAGE-2:0], in_valid};

   always_comb begin
      logic signed [42:0] dt2;
      logic signed [59:0] ddt3;
      logic signed [71:0] tsh;
      logic signed [57:0] tqq;
      logic signed [52:0] hq;
      logic signed [45:0] lq;
      logic signed [45:0] p6q;
      logic signed [47:0] p7s;
      logic signed [57:0] p8c;
      logic signed [16:0] p1m;
      logic signed [16:0] p2m;
      logic signed [45:0] p2q;
      logic signed [47:0] p3s;
      logic signed [57:0] p4c;
      logic signed [36:0] p10q;
      logic signed [64:0] uq;
      logic signed [58:0] cu;
      logic signed [64:0] uk;
      logic signed [64:0] kuu;
      logic signed [55:0] wide;
      logic signed [55:0] pr;
      // stage 1
      d_in  = $signed({2'b00, in_ut}) - (26'(trim.t1) <<< 8);
      dd_in = 52'(d_in) * 52'(d_in);
      // stage 2
      dt2   = 43'(d_ff) * 43'(trim.t2);
      ddt3  = 60'(dd_ff) * 60'(trim.t3);
      tn_in = (72'(dt2) <<< 18) + 72'(ddt3);
      // stage 3
      tsh   = tn_ff >>> (48 - TEMP_FRACTION_BITS);
      tsat3_in = 1'b0;
      if (tsh > 72'sd8388607) begin
         temp3_in = 24'h7fffff; tsat3_in = 1'b1;
      end else if (tsh < -72'sd8388608) begin
         temp3_in = 24'h800000; tsat3_in = 1'b1;
      end else begin
         temp3_in = tsh[23:0];
      end
      tq3_in   = 29'(tn_ff >>> 32);
      tqq      = 58'(tq3_in) * 58'(tq3_in);
      tsq3_in  = 40'(tqq >>> 16);
      upup3_in = 50'(up2_ff) * 50'(up2_ff);
      // stage 4: cube split in upper and lower halves of the square
      hq = 53'($signed(tsq3_ff[39:16])) * 53'(tq3_ff);
      lq = 46'($signed({1'b0, tsq3_ff[15:0]})) * 46'(tq3_ff);
      tcu4_in   = 50'(hq) + 50'(lq >>> 16);
      p11uu4_in = 60'(trim.p11) * 60'(upup3_ff);
      // stage 5
      p6q = 46'(trim.p6) * 46'(tq4_ff);
      p7s = 48'(trim.p7) * 48'(tsq4_ff);
      p8c = 58'(trim.p8) * 58'(tcu4_ff);
      acc5_in = (48'(trim.p5) <<< 19) + 48'(p6q >>> 6) + 48'(p7s >>> 8)
              + 48'(p8c >>> 15);
      p1m = 17'(trim.p1) - 17'sd16384;
      p2m = 17'(trim.p2) - 17'sd16384;
      p2q = 46'(p2m) * 46'(tq4_ff);
      p3s = 48'(trim.p3) * 48'(tsq4_ff);
      p4c = 58'(trim.p4) * 58'(tcu4_ff);
      q5_in = (40'(p1m) <<< 16) + 40'(p2q >>> 9) + 40'(p3s >>> 12)
            + 40'(p4c >>> 17);
      p10q  = 37'(trim.p10) * 37'(tq4_ff);
      k5_in = (40'(trim.p9) <<< 16) + 40'(p10q);
      c5_in = 34'(p11uu4_ff >>> 24);
      // stage 6
      uq = 65'(up5_ff) * 65'(q5_ff);
      cu = 59'(c5_ff) * 59'(up5_ff);
      acc6_in = 56'(acc5_ff) + 56'(uq >>> 20) + 56'(cu >>> 25);
      uk = 65'(up5_ff) * 65'(k5_ff);
      ku6_in = 40'(uk >>> 24);
      // stage 7
      kuu  = 65'(ku6_ff) * 65'(up6_ff);
      wide = acc6_ff + 56'(kuu >>> 24);
      pr   = wide >>> (16 - PRESSURE_FRACTION_BITS);
      sat7_in = tsat6_ff;
      if (pr < 0) begin
         pres7_in = '0; sat7_in = 1'b1;
      end else if (pr > 56'sd16777215) begin
         pres7_in = 24'hffffff; sat7_in = 1'b1;
      end else begin
         pres7_in = pr[23:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // payload stages, all move together
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff <= d_in; dd_ff <= dd_in; up1_ff <= $signed({1'b0, in_up});
         tn_ff <= tn_in; up2_ff <= up1_ff;
         tq3_ff <= tq3_in; tsq3_ff <= tsq3_in; temp3_ff <= temp3_in;
         tsat3_ff <= tsat3_in; up3_ff <= up2_ff; upup3_ff <= upup3_in;
         tcu4_ff <= tcu4_in; tsq4_ff <= tsq3_ff; tq4_ff <= tq3_ff;
         temp4_ff <= temp3_ff; tsat4_ff <= tsat3_ff; up4_ff <= up3_ff;
         p11uu4_ff <= p11uu4_in;
         acc5_ff <= acc5_in; q5_ff <= q5_in; k5_ff <= k5_in; c5_ff <= c5_in;
         temp5_ff <= temp4_ff; tsat5_ff <= tsat4_ff; up5_ff <= up4_ff;
         acc6_ff <= acc6_in; ku6_ff <= ku6_in; temp6_ff <= temp5_ff;
         tsat6_ff <= tsat5_ff; up6_ff <= up5_ff;
         temp7_ff <= temp6_ff; pres7_ff <= pres7_in; sat7_ff <= sat7_in;
      end
   end

   assign out_valid = vld_ff[NSTAGE-1];
   assign out_temp  = temp7_ff;
   assign out_pres  = pres7_ff;
   assign out_sat   = sat7_ff;

endmodule

// ----- design/barometric_sensor_compensation.sv -----
// Barometric temperature and pressure compensation.
// req_ channel: one raw reading per transfer, tdata = {raw_pressure, raw_temperature}.
// rsp_ channel: one compensated result per reading, in order,
//   tdata = {saturated, pressure, temperature}, zero padded to 56 bits.
// csr_ channel: writes trim register csr_index with csr_data; always ready.
//   Write only while no reading is in flight.
// A result moves through the same seven pipeline registers as its valid bit;
//   rsp_tvalid is the valid bit of the last stage.
// Throughput: one reading per cycle while rsp_tready does not stall; the seven-stage
//   arithmetic pipeline moves as one whole.
// A stall on rsp_tready freezes the whole pipeline; req_tready falls with it
//   when the last stage holds a result, so nothing is lost or repeated.
// Reset clears the valid bits and all trim registers to zero.
module barometric_sensor_compensation #(
   parameter int TEMP_FRACTION_BITS     = bsc_pkg::TEMP_FRACTION_BITS_DEF,
   parameter int PRESSURE_FRACTION_BITS = bsc_pkg::PRESSURE_FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [47:0]                    req_tdata,  // raw_temperature, raw_pressure
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [55:0]                    rsp_tdata,  // temperature, pressure, saturated
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bsc_pkg::*;

   trim_type    trim;
   logic        advance;
   logic [23:0] t_o, p_o;
   logic        s_o;

   bsc_regs u_regs (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .trim
   );

   // pipeline moves when the output slot is empty or drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   bsc_pipe #(
      .TEMP_FRACTION_BITS(TEMP_FRACTION_BITS),
      .PRESSURE_FRACTION_BITS(PRESSURE_FRACTION_BITS)
   ) u_pipe (
      .clock, .reset, .trim, .advance,
      .in_valid(req_tvalid), .in_ut(req_tdata[23:0]), .in_up(req_tdata[47:24]),
      .out_valid(rsp_tvalid), .out_temp(t_o), .out_pres(p_o), .out_sat(s_o)
   );

   assign rsp_tdata = {7'b0, s_o, p_o, t_o};

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready not tied to output slot");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47:24] != 24'hffffff && rsp_tdata[47:24] != 24'h0
      && rsp_tdata[23:0] != 24'h7fffff && rsp_tdata[23:0] != 24'h800000
      |-> !rsp_tdata[48])
      else $error("saturation flag without clamped value");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import bsc_pkg::*;

   localparam int TFB = TEMP_FRACTION_BITS_DEF;
   localparam int PFB = PRESSURE_FRACTION_BITS_DEF;

   // wide signed arithmetic so no intermediate product can wrap
   typedef logic signed [127:0] wide_type;

   // compensation predictor and store of expected readings
   class compensation_scoreboard;
      logic [47:0] trim_regs [4];
      logic [48:0] pending_readings [$];
      int errors;

      function void write_trim(logic [CSR_ADDR_W-1:0] idx, logic [47:0] value);
         if (idx == REG_TEMP_TRIM)
            trim_regs[0] = {8'd0, value[39:0]};
         else if (idx == REG_PRESS_LOW)
            trim_regs[1] = value;
         else if (idx == REG_PRESS_MID)
            trim_regs[2] = value;
         else if (idx == REG_PRESS_HIGH)
            trim_regs[3] = {16'd0, value[31:0]};
      endfunction

      function void note_reading(logic [23:0] raw_t, logic [23:0] raw_p);
         wide_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
         wide_type d, tn, tq, tsq, tcu, acc, q, k, up, temp, pres;
         logic sat;
         t1  = {112'd0, trim_regs[0][15:0]};
         t2  = {112'd0, trim_regs[0][31:16]};
         t3  = {{120{trim_regs[0][39]}}, trim_regs[0][39:32]};
         p1  = {{112{trim_regs[1][15]}}, trim_regs[1][15:0]};
         p2  = {{112{trim_regs[1][31]}}, trim_regs[1][31:16]};
         p3  = {{120{trim_regs[1][39]}}, trim_regs[1][39:32]};
         p4  = {{120{trim_regs[1][47]}}, trim_regs[1][47:40]};
         p5  = {112'd0, trim_regs[2][15:0]};
         p6  = {112'd0, trim_regs[2][31:16]};
         p7  = {{120{trim_regs[2][39]}}, trim_regs[2][39:32]};
         p8  = {{120{trim_regs[2][47]}}, trim_regs[2][47:40]};
         p9  = {{112{trim_regs[3][15]}}, trim_regs[3][15:0]};
         p10 = {{120{trim_regs[3][23]}}, trim_regs[3][23:16]};
         p11 = {{120{trim_regs[3][31]}}, trim_regs[3][31:24]};
         up  = {104'd0, raw_p};
         sat = 1'b0;
         // temperature, exact, scaled by 2^48
         d  = wide_type'({104'd0, raw_t}) - t1 * 256;
         tn = d * t2 * 262144 + d * d * t3;
         temp = tn >>> (48 - TFB);
         if (temp > 8388607) begin
            temp = 8388607;
            sat = 1'b1;
         end
         if (temp < -8388608) begin
            temp = -8388608;
            sat = 1'b1;
         end
         // powers of temperature at 2^16
         tq  = tn >>> 32;
         tsq = (tq * tq) >>> 16;
         tcu = (tsq * tq) >>> 16;
         // pressure terms summed at 2^16
         acc = p5 * 524288;
         acc = acc + ((p6 * tq) >>> 6) + ((p7 * tsq) >>> 8) + ((p8 * tcu) >>> 15);
         q = (p1 - 16384) * 65536 + (((p2 - 16384) * tq) >>> 9)
             + ((p3 * tsq) >>> 12) + ((p4 * tcu) >>> 17);
         acc = acc + ((up * q) >>> 20);
         k = p9 * 65536 + p10 * tq;
         acc = acc + ((((up * k) >>> 24) * up) >>> 24);
         acc = acc + ((((p11 * up * up) >>> 24) * up) >>> 25);
         pres = acc >>> (16 - PFB);
         if (pres < 0) begin
            pres = 0;
            sat = 1'b1;
         end
         if (pres > 16777215) begin
            pres = 16777215;
            sat = 1'b1;
         end
         pending_readings.push_back({sat, pres[23:0], temp[23:0]});
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_result(logic [55:0] data);
         logic [48:0] want;
         if (pending_readings.size() == 0) begin
            report("unexpected result", data[31:0], 32'd0);
         end else begin
            want = pending_readings.pop_front();
            if (data[23:0] !== want[23:0])
               report("temperature", 32'(data[23:0]), 32'(want[23:0]));
            if (data[47:24] !== want[47:24])
               report("pressure", 32'(data[47:24]), 32'(want[47:24]));
            if (data[48] !== want[48])
               report("saturated", 32'(data[48]), 32'(want[48]));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [47:0] req_tdata;  // raw_temperature, raw_pressure
   logic rsp_tvalid;
   logic rsp_tready;
   logic [55:0] rsp_tdata;  // temperature, pressure, saturated
   logic csr_valid;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   compensation_scoreboard readings;
   bit calm;
   logic [15:0] base_t1;

   barometric_sensor_compensation i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // transfer monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            readings.note_reading(req_tdata[23:0], req_tdata[47:24]);
         if (rsp_tvalid && rsp_tready)
            readings.check_result(rsp_tdata);
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            rsp_tready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // overall limit
   initial begin
      #20ms;
      $display("barometric_sensor_compensation test failed");
      $finish;
   end

   task send_reading(logic [23:0] raw_t, logic [23:0] raw_p);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_p, raw_t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (readings.pending_readings.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task write_csr(logic [CSR_ADDR_W-1:0] idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      readings.write_trim(idx, value);
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // readings near the trim offset keep the polynomials in range
   task random_readings(int count);
      logic [23:0] raw_t;
      repeat (count) begin
         if ($urandom_range(0, 3) != 0)
            raw_t = {base_t1, 8'd0} + 24'($signed($urandom_range(0, 131071)) - 65536);
         else
            raw_t = 24'($urandom());
         send_reading(raw_t, 24'($urandom()));
      end
   endtask

   task directed_readings();
      send_reading(24'd0, 24'd0);
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      send_reading(24'd0, 24'hFFFFFF);
      send_reading(24'hFFFFFF, 24'd0);
      send_reading({base_t1, 8'd0}, 24'h800000);
      send_reading({base_t1, 8'd0} + 24'd1, 24'h555555);
      send_reading({base_t1, 8'd0} - 24'd1, 24'hAAAAAA);
   endtask

   task set_trims(logic [47:0] tt, logic [47:0] pl, logic [47:0] pm, logic [47:0] ph);
      write_csr(CSR_ADDR_W'(REG_TEMP_TRIM), tt);
      write_csr(CSR_ADDR_W'(REG_PRESS_LOW), pl);
      write_csr(CSR_ADDR_W'(REG_PRESS_MID), pm);
      write_csr(CSR_ADDR_W'(REG_PRESS_HIGH), ph);
      // out-of-range indexes must be ignored
      write_csr(CSR_ADDR_W'(4 + $urandom_range(0, 3)), rand48());
      csr_valid <= 1'b0;
      base_t1 = tt[15:0];
   endtask

   initial begin
      readings = new();
      foreach (readings.trim_regs[i]) readings.trim_regs[i] = '0;
      calm = 1'b0;
      base_t1 = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // trims at reset value
      directed_readings();
      random_readings(60);
      drain();

      // typical sensor-like trims
      set_trims(48'h00F8_6B26_6A00, {8'hFD, 8'h10, 16'h0400, 16'h4E00},
                {8'hFA, 8'h03, 16'h7600, 16'h6700}, 48'({8'h00, 8'h04, 16'h0F00}));
      directed_readings();
      random_readings(300);
      drain();

      // all ones
      set_trims({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
      directed_readings();
      random_readings(80);
      drain();

      // most negative signed fields, unsigned fields at zero or max
      set_trims(48'h0080_FFFF_0000, 48'h8080_8000_8000, 48'h8080_FFFF_0000,
                48'h8080_8000);
      directed_readings();
      random_readings(80);
      drain();

      // fully random trims, several rounds
      repeat (7) begin
         set_trims(rand48(), rand48(), rand48(), rand48());
         directed_readings();
         random_readings(100);
         drain();
      end

      // back to typical trims, last stretch without idling
      set_trims(48'h0028_6F00_6B00, {8'h05, 8'hF8, 16'h3A00, 16'h5000},
                {8'h02, 8'hFE, 16'h8000, 16'h6000}, 48'({8'hFF, 8'h02, 16'h1200}));
      random_readings(60);
      calm = 1'b1;
      random_readings(150);
      drain();

      if (readings.errors == 0)
         $display("barometric_sensor_compensation test passed");
      else
         $display("barometric_sensor_compensation test failed");
      $finish;
   end

endmodule

// ----- barometric_sensor_compensation.f -----
design/bsc_pkg.sv
design/bsc_regs.sv
design/bsc_pipe.sv
design/barometric_sensor_compensation.sv
tb/testbench.sv
